// File: rtl/core/rbes_pkg.sv
// Shared types and constants for the rigid body Euler step core.
// Used by rbes_dp, rbes_ctrl and rigid_body_euler_step_core; no dependencies.
package rbes_pkg;

  localparam int QW = 32;
  localparam int ACCW = 50;
  localparam int DTW = 16;
  localparam int INVMW = 31;

  localparam logic [QW-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [QW-1:0] Q_ZERO = 32'h0000_0000;

  localparam logic [2:0] CFG_INV_MASS = 3'd0;
  localparam logic [2:0] CFG_IXX = 3'd1;
  localparam logic [2:0] CFG_IYY = 3'd2;
  localparam logic [2:0] CFG_IZZ = 3'd3;
  localparam logic [2:0] CFG_IXY = 3'd4;
  localparam logic [2:0] CFG_IXZ = 3'd5;
  localparam logic [2:0] CFG_IYZ = 3'd6;

  // Register file addresses (6 bits)
  // 0..2 pos, 3..5 vel, 6..8 L, 9..17 R, 18..26 tmp A, 27..35 tmp B
  // operand sources also include force, torque, inertia and k/dt via src codes
  localparam int NSTATE = 18;
  localparam int NSCR = 18;

  typedef enum logic [2:0] {
    SRC_REG,
    SRC_FORCE,
    SRC_TORQUE,
    SRC_INERTIA,
    SRC_DT,
    SRC_K,
    SRC_ZERO
  } src_t;

  // One operation step of the microcode.
  // acc = (first ? 0 : acc) + rnd(a*b), with optional add of a register at end.
  typedef struct packed {
    src_t       a_src;
    logic [5:0] a_idx;
    logic       a_neg;
    src_t       b_src;
    logic [5:0] b_idx;
    logic       first;
    logic       last;
    logic       add_reg;
    logic [5:0] dst;
    logic       to_k;
  } uop_t;

  typedef struct packed {
    logic       start;
    logic [6:0] pc;
    logic       load_out;
  } dp_cmd_t;

  function automatic uop_t mk(src_t as, logic [5:0] ai, logic an, src_t bs, logic [5:0] bi,
                              logic f, logic l, logic ar, logic [5:0] d, logic tk);
    uop_t u;
    u.a_src = as; u.a_idx = ai; u.a_neg = an; u.b_src = bs; u.b_idx = bi;
    u.first = f; u.last = l; u.add_reg = ar; u.dst = d; u.to_k = tk;
    return u;
  endfunction

  // Skew entry of star(w): returns (is_zero, w index, negate) for row r col c
  function automatic logic [3:0] skew(int r, int c);
    logic [3:0] s;
    s = 4'b1000;
    if (r == 0 && c == 1) s = {1'b0, 2'd2, 1'b1};
    if (r == 0 && c == 2) s = {1'b0, 2'd1, 1'b0};
    if (r == 1 && c == 0) s = {1'b0, 2'd2, 1'b0};
    if (r == 1 && c == 2) s = {1'b0, 2'd0, 1'b1};
    if (r == 2 && c == 0) s = {1'b0, 2'd1, 1'b1};
    if (r == 2 && c == 1) s = {1'b0, 2'd0, 1'b0};
    return s;
  endfunction

  // Inertia matrix entry index (0..5) for row r col c of the symmetric matrix
  function automatic logic [5:0] ib_idx(int r, int c);
    if (r == c) return 6'(r);
    if ((r == 0 && c == 1) || (r == 1 && c == 0)) return 6'd3;
    if ((r == 0 && c == 2) || (r == 2 && c == 0)) return 6'd4;
    return 6'd5;
  endfunction

  // Microcode table, one entry per pc; loops run over constants only.
  function automatic uop_t prog(logic [6:0] pc);
    uop_t u;
    logic [3:0] s;
    u = mk(SRC_ZERO, 6'd0, 1'b0, SRC_ZERO, 6'd0, 1'b1, 1'b1, 1'b0, 6'd0, 1'b0);
    if (pc == 7'd0)
      u = mk(SRC_DT, 6'd0, 1'b0, SRC_K, 6'd0, 1'b1, 1'b1, 1'b0, 6'd0, 1'b1);
    for (int i = 0; i < 3; i++) begin
      if (pc == 7'(1 + 3 * i))
        u = mk(SRC_FORCE, 6'(i), 1'b0, SRC_K, 6'd0, 1'b1, 1'b1, 1'b1, 6'(3 + i), 1'b0);
      if (pc == 7'(2 + 3 * i))
        u = mk(SRC_REG, 6'(3 + i), 1'b0, SRC_DT, 6'd0, 1'b1, 1'b1, 1'b1, 6'(i), 1'b0);
      if (pc == 7'(3 + 3 * i))
        u = mk(SRC_TORQUE, 6'(i), 1'b0, SRC_DT, 6'd0, 1'b1, 1'b1, 1'b1, 6'(6 + i), 1'b0);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          // M = R * Ib -> tmp A (18..26)
          if (pc == 7'(10 + r * 9 + c * 3 + j))
            u = mk(SRC_REG, 6'(9 + r * 3 + j), 1'b0, SRC_INERTIA, ib_idx(j, c),
                   j == 0, j == 2, 1'b0, 6'(18 + r * 3 + c), 1'b0);
          // Iw = M * R^T -> tmp B (27..35); R^T[j][c] = R[c][j]
          if (pc == 7'(37 + r * 9 + c * 3 + j))
            u = mk(SRC_REG, 6'(18 + r * 3 + j), 1'b0, SRC_REG, 6'(9 + c * 3 + j),
                   j == 0, j == 2, 1'b0, 6'(27 + r * 3 + c), 1'b0);
          // D = star(w) * R -> tmp B (27..35)
          s = skew(r, j);
          if (pc == 7'(73 + r * 9 + c * 3 + j))
            u = mk(s[3] ? SRC_ZERO : SRC_REG, 6'(18 + int'(s[2:1])), s[0], SRC_REG,
                   6'(9 + j * 3 + c), j == 0, j == 2, 1'b0, 6'(27 + r * 3 + c), 1'b0);
        end
      end
    end
    // w = Iw * L -> tmp A (18..20)
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        if (pc == 7'(64 + r * 3 + j))
          u = mk(SRC_REG, 6'(27 + r * 3 + j), 1'b0, SRC_REG, 6'(6 + j),
                 j == 0, j == 2, 1'b0, 6'(18 + r), 1'b0);
      end
    end
    // R += D * dt
    for (int st = 0; st < 9; st++) begin
      if (pc == 7'(100 + st))
        u = mk(SRC_REG, 6'(27 + st), 1'b0, SRC_DT, 6'd0, 1'b1, 1'b1, 1'b1, 6'(9 + st), 1'b0);
    end
    return u;
  endfunction

  localparam int NPROG = 109;

endpackage

// File: rtl/core/rigid_body_euler_step_core.sv
// Rigid body explicit Euler step core, signed Q16.16 with saturation.
// One transaction in gives one transaction out: 109 multiply-round-accumulate
// operations on one shared 33x33 multiplier, then a load of the output register.
// One tick is processed at a time; the input stalls until its result is in the
// output register, so a new tick is taken only once the last one is through.
module rigid_body_euler_step_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        step_time,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] torque_x,
  input  logic signed [31:0] torque_y,
  input  logic signed [31:0] torque_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] rot_r0c0,
  output logic signed [31:0] rot_r0c1,
  output logic signed [31:0] rot_r0c2,
  output logic signed [31:0] rot_r1c0,
  output logic signed [31:0] rot_r1c1,
  output logic signed [31:0] rot_r1c2,
  output logic signed [31:0] rot_r2c0,
  output logic signed [31:0] rot_r2c1,
  output logic signed [31:0] rot_r2c2
);

  rbes_pkg::dp_cmd_t cmd;
  logic in_take;
  logic [31:0] res [12];

  rbes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .in_take(in_take), .cmd(cmd)
  );

  rbes_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_take(in_take), .step_time(step_time),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
    .cmd(cmd), .res(res)
  );

  assign pos_x = res[0];
  assign pos_y = res[1];
  assign pos_z = res[2];
  assign rot_r0c0 = res[3];
  assign rot_r0c1 = res[4];
  assign rot_r0c2 = res[5];
  assign rot_r1c0 = res[6];
  assign rot_r1c1 = res[7];
  assign rot_r1c2 = res[8];
  assign rot_r2c0 = res[9];
  assign rot_r2c1 = res[10];
  assign rot_r2c2 = res[11];

endmodule

// File: rtl/core/rbes_dp.sv
// Datapath: state register file, shared multiply-accumulate unit and output register.
// Depends on rbes_pkg; sequenced by rbes_ctrl.
module rbes_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_idx,
  input  logic [rbes_pkg::QW-1:0]       cfg_data,
  input  logic                          in_take,
  input  logic [rbes_pkg::DTW-1:0]      step_time,
  input  logic signed [rbes_pkg::QW-1:0] force_x,
  input  logic signed [rbes_pkg::QW-1:0] force_y,
  input  logic signed [rbes_pkg::QW-1:0] force_z,
  input  logic signed [rbes_pkg::QW-1:0] torque_x,
  input  logic signed [rbes_pkg::QW-1:0] torque_y,
  input  logic signed [rbes_pkg::QW-1:0] torque_z,
  input  rbes_pkg::dp_cmd_t             cmd,
  output logic [rbes_pkg::QW-1:0]       res [12]
);

  localparam logic signed [rbes_pkg::ACCW-1:0] ACC_MAX = rbes_pkg::ACCW'(64'sd2147483647);
  localparam logic signed [rbes_pkg::ACCW-1:0] ACC_MIN = rbes_pkg::ACCW'(-64'sd2147483648);

  logic [rbes_pkg::INVMW-1:0] inv_mass;
  logic [rbes_pkg::QW-1:0] inertia [6];
  logic [rbes_pkg::QW-1:0] body_rf [rbes_pkg::NSTATE];
  logic [rbes_pkg::QW-1:0] tmp_rf [rbes_pkg::NSCR];
  logic [rbes_pkg::DTW-1:0] dt;
  logic [rbes_pkg::QW-1:0] frc [3];
  logic [rbes_pkg::QW-1:0] trq [3];
  logic [rbes_pkg::QW-1:0] kreg;
  logic signed [rbes_pkg::ACCW-1:0] acc;

  rbes_pkg::uop_t u;
  logic [rbes_pkg::QW-1:0] a_rf;
  logic [rbes_pkg::QW-1:0] b_rf;
  logic [rbes_pkg::QW-1:0] d_rf;
  logic signed [32:0] a_op;
  logic signed [32:0] b_op;
  logic signed [65:0] prod;
  logic signed [65:0] prod_r;
  logic signed [rbes_pkg::ACCW-1:0] rnd_v;
  logic signed [rbes_pkg::ACCW-1:0] acc_sum;
  logic signed [rbes_pkg::ACCW-1:0] fin;
  logic [rbes_pkg::QW-1:0] sat_v;
  rbes_pkg::uop_t u_r;
  logic v_r;

  function automatic logic signed [32:0] pick(rbes_pkg::src_t s, logic [5:0] idx,
      logic [rbes_pkg::QW-1:0] rfv, logic [rbes_pkg::QW-1:0] fv, logic [rbes_pkg::QW-1:0] tv,
      logic [rbes_pkg::QW-1:0] iv, logic [rbes_pkg::DTW-1:0] d, logic [rbes_pkg::QW-1:0] k,
      logic [rbes_pkg::INVMW-1:0] im);
    logic signed [32:0] v;
    unique case (s)
      rbes_pkg::SRC_REG:     v = {rfv[31], rfv};
      rbes_pkg::SRC_FORCE:   v = {fv[31], fv};
      rbes_pkg::SRC_TORQUE:  v = {tv[31], tv};
      rbes_pkg::SRC_INERTIA: v = {iv[31], iv};
      rbes_pkg::SRC_DT:      v = {17'd0, d};
      rbes_pkg::SRC_K:       v = (idx == 6'd0) && (u.to_k) ? {2'b0, im} : {k[31], k};
      default:               v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_clip(logic signed [rbes_pkg::ACCW-1:0] x);
    if (x > ACC_MAX) return 32'h7fff_ffff;
    if (x < ACC_MIN) return 32'h8000_0000;
    return x[31:0];
  endfunction

  always_comb begin
    u = rbes_pkg::prog(cmd.pc);
    a_rf = (u.a_idx < 6'(rbes_pkg::NSTATE)) ? body_rf[5'(u.a_idx)] :
           tmp_rf[5'(u.a_idx - 6'(rbes_pkg::NSTATE))];
    b_rf = (u.b_idx < 6'(rbes_pkg::NSTATE)) ? body_rf[5'(u.b_idx)] :
           tmp_rf[5'(u.b_idx - 6'(rbes_pkg::NSTATE))];
    a_op = pick(u.a_src, u.a_idx, a_rf, frc[u.a_idx[1:0]], trq[u.a_idx[1:0]],
                inertia[u.a_idx[2:0]], dt, kreg, inv_mass);
    if (u.a_neg) a_op = -a_op;
    b_op = pick(u.b_src, u.b_idx, b_rf, frc[u.b_idx[1:0]], trq[u.b_idx[1:0]],
                inertia[u.b_idx[2:0]], dt, kreg, inv_mass);
    prod = a_op * b_op;
  end

  // rounded terms are summed exactly; a result is saturated once, or before and after its register add; k is truncated
  always_comb begin
    d_rf = (u_r.dst < 6'(rbes_pkg::NSTATE)) ? body_rf[5'(u_r.dst)] :
           tmp_rf[5'(u_r.dst - 6'(rbes_pkg::NSTATE))];
    rnd_v = rbes_pkg::ACCW'((prod_r + 66'sd32768) >>> 16);
    acc_sum = (u_r.first ? {rbes_pkg::ACCW{1'b0}} : acc) + rnd_v;
    fin = u_r.add_reg ? rbes_pkg::ACCW'($signed(d_rf)) +
                        rbes_pkg::ACCW'($signed(sat_clip(acc_sum))) : acc_sum;
    sat_v = sat_clip(fin);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    u_r <= u;
    if (rst) begin
      v_r <= 1'b0;
      inv_mass <= rbes_pkg::INVMW'(rbes_pkg::Q_ONE);
      inertia[0] <= rbes_pkg::Q_ONE;
      inertia[1] <= rbes_pkg::Q_ONE;
      inertia[2] <= rbes_pkg::Q_ONE;
      inertia[3] <= rbes_pkg::Q_ZERO;
      inertia[4] <= rbes_pkg::Q_ZERO;
      inertia[5] <= rbes_pkg::Q_ZERO;
      for (int i = 0; i < rbes_pkg::NSTATE; i++)
        body_rf[i] <= (i == 9 || i == 13 || i == 17) ? rbes_pkg::Q_ONE : rbes_pkg::Q_ZERO;
    end else begin
      v_r <= cmd.start;
      if (cfg_we) begin
        unique case (cfg_idx)
          rbes_pkg::CFG_INV_MASS: inv_mass <= cfg_data[rbes_pkg::INVMW-1:0];
          rbes_pkg::CFG_IXX: inertia[0] <= cfg_data;
          rbes_pkg::CFG_IYY: inertia[1] <= cfg_data;
          rbes_pkg::CFG_IZZ: inertia[2] <= cfg_data;
          rbes_pkg::CFG_IXY: inertia[3] <= cfg_data;
          rbes_pkg::CFG_IXZ: inertia[4] <= cfg_data;
          rbes_pkg::CFG_IYZ: inertia[5] <= cfg_data;
          default: ;
        endcase
      end
      if (v_r) begin
        acc <= acc_sum;
        if (u_r.last) begin
          if (u_r.to_k) kreg <= acc_sum[31:0];
          else if (u_r.dst < 6'(rbes_pkg::NSTATE)) body_rf[5'(u_r.dst)] <= sat_v;
          else tmp_rf[5'(u_r.dst - 6'(rbes_pkg::NSTATE))] <= sat_v;
        end
      end
    end
    if (in_take) begin
      dt <= step_time;
      frc[0] <= force_x; frc[1] <= force_y; frc[2] <= force_z;
      trq[0] <= torque_x; trq[1] <= torque_y; trq[2] <= torque_z;
    end
    if (cmd.load_out) begin
      for (int i = 0; i < 3; i++) res[i] <= body_rf[i];
      for (int i = 0; i < 9; i++) res[3 + i] <= body_rf[9 + i];
    end
  end

endmodule

// File: rtl/core/rbes_ctrl.sv
// Controller: steps through the microcode, an ISSUE and a WAIT state per operation.
// Depends on rbes_pkg; drives rbes_dp.
module rbes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              in_take,
  output rbes_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, DRAIN} state_t;
  state_t state;
  logic [6:0] pc;

  assign in_stall = (state != IDLE);
  assign in_take = in_valid && (state == IDLE);

  always_comb begin
    cmd.start = (state == ISSUE);
    cmd.pc = pc;
    cmd.load_out = (state == DRAIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pc <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == DRAIN) && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        IDLE: if (in_valid) begin
          state <= ISSUE;
          pc <= '0;
        end
        ISSUE: state <= WAIT;
        WAIT: begin
          if (pc == 7'(rbes_pkg::NPROG - 1)) state <= DRAIN;
          else begin
            pc <= pc + 7'd1;
            state <= ISSUE;
          end
        end
        DRAIN: if (!out_valid || !out_stall) begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/rbes_checker.sv
// Scoreboard for rigid_body_euler_step_core: mirrors config writes, predicts each tick.
// Compares every output transaction with the oldest prediction. Depends on rbes_pkg.
module rbes_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        step_time,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic signed [31:0] torque_x,
  input  logic signed [31:0] torque_y,
  input  logic signed [31:0] torque_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] rot_r0c0,
  input  logic signed [31:0] rot_r0c1,
  input  logic signed [31:0] rot_r0c2,
  input  logic signed [31:0] rot_r1c0,
  input  logic signed [31:0] rot_r1c1,
  input  logic signed [31:0] rot_r1c2,
  input  logic signed [31:0] rot_r2c0,
  input  logic signed [31:0] rot_r2c1,
  input  logic signed [31:0] rot_r2c2,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [11:0][31:0] pose_t;

  longint mass_recip;
  longint inertia[6];
  longint pos[3];
  longint vel[3];
  longint ang_mom[3];
  longint rot[9];
  pose_t  pose_q[$];

  function automatic longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qround(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint qdot(longint a0, longint a1, longint a2,
                                  longint b0, longint b1, longint b2);
    return clamp(qround(a0, b0) + qround(a1, b1) + qround(a2, b2));
  endfunction

  function automatic void mat3(input longint a[9], input longint b[9], output longint c[9]);
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        c[r*3+k] = qdot(a[r*3], a[r*3+1], a[r*3+2], b[k], b[3+k], b[6+k]);
  endfunction

  function automatic pose_t integrate_tick(longint dt, longint f[3], longint t[3]);
    longint kdt, ib[9], rt[9], m[9], iw[9], w[3], sk[9], d[9];
    pose_t res;
    kdt = qround(dt, mass_recip);
    for (int i = 0; i < 3; i++) begin
      vel[i] = clamp(vel[i] + clamp(qround(f[i], kdt)));
      pos[i] = clamp(pos[i] + clamp(qround(vel[i], dt)));
      ang_mom[i] = clamp(ang_mom[i] + clamp(qround(t[i], dt)));
    end
    ib[0] = inertia[0]; ib[4] = inertia[1]; ib[8] = inertia[2];
    ib[1] = inertia[3]; ib[3] = inertia[3];
    ib[2] = inertia[4]; ib[6] = inertia[4];
    ib[5] = inertia[5]; ib[7] = inertia[5];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) rt[r*3+c] = rot[c*3+r];
    mat3(rot, ib, m);
    mat3(m, rt, iw);
    for (int r = 0; r < 3; r++)
      w[r] = qdot(iw[r*3], iw[r*3+1], iw[r*3+2], ang_mom[0], ang_mom[1], ang_mom[2]);
    sk[0] = 0;     sk[1] = -w[2]; sk[2] = w[1];
    sk[3] = w[2];  sk[4] = 0;     sk[5] = -w[0];
    sk[6] = -w[1]; sk[7] = w[0];  sk[8] = 0;
    mat3(sk, rot, d);
    for (int i = 0; i < 9; i++) rot[i] = clamp(rot[i] + clamp(qround(d[i], dt)));
    for (int i = 0; i < 3; i++) res[i] = pos[i][31:0];
    for (int i = 0; i < 9; i++) res[3+i] = rot[i][31:0];
    return res;
  endfunction

  assign pending = pose_q.size();

  always @(posedge clk) begin
    longint f[3], t[3];
    pose_t got, want;
    if (rst) begin
      fails <= 0;
      mass_recip = 65536;
      inertia = '{65536, 65536, 65536, 0, 0, 0};
      pos = '{0, 0, 0};
      vel = '{0, 0, 0};
      ang_mom = '{0, 0, 0};
      rot = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == rbes_pkg::CFG_INV_MASS) mass_recip = longint'({1'b0, cfg_data[30:0]});
        else if (cfg_idx <= rbes_pkg::CFG_IYZ)
          inertia[cfg_idx - 1] = longint'(signed'(cfg_data));
      end
      if (in_valid && !in_stall) begin
        f = '{force_x, force_y, force_z};
        t = '{torque_x, torque_y, torque_z};
        pose_q.insert(pose_q.size(), integrate_tick(longint'({1'b0, step_time}), f, t));
      end
      if (out_valid && !out_stall) begin
        got = {rot_r2c2, rot_r2c1, rot_r2c0, rot_r1c2, rot_r1c1, rot_r1c0,
               rot_r0c2, rot_r0c1, rot_r0c0, pos_z, pos_y, pos_x};
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected output transaction %h", $realtime, got);
          fails <= fails + 1;
        end else begin
          want = pose_q.pop_front();
          if (got != want) begin
            for (int i = 0; i < 12; i++)
              if (got[i] != want[i])
                $display("%0t: field %0d expected %h actual %h", $realtime, i,
                         want[i], got[i]);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/tb.sv
// Top testbench for rigid_body_euler_step_core: clock, reset, config phases, stimulus.
// Instantiates the core and rbes_checker; depends on rbes_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] step_time = '0;
  logic signed [31:0] force_x = 0, force_y = 0, force_z = 0;
  logic signed [31:0] torque_x = 0, torque_y = 0, torque_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2;
  logic signed [31:0] rot_r2c0, rot_r2c1, rot_r2c2;
  int fails, pending;
  int sent = 0;

  always #4 clk = ~clk;

  rigid_body_euler_step_core DUT (.*);
  rbes_checker chk (.*);

  function automatic logic [31:0] pick_q();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return $urandom;
    if (mode == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (mode == 2) return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
    return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1; cfg_idx = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_body(logic [31:0] m, logic [31:0] xx, logic [31:0] yy,
                           logic [31:0] zz, logic [31:0] xy, logic [31:0] xz,
                           logic [31:0] yz);
    wait (pending == 0);
    repeat (300) @(negedge clk);
    reg_write(rbes_pkg::CFG_INV_MASS, m);
    reg_write(rbes_pkg::CFG_IXX, xx);
    reg_write(rbes_pkg::CFG_IYY, yy);
    reg_write(rbes_pkg::CFG_IZZ, zz);
    reg_write(rbes_pkg::CFG_IXY, xy);
    reg_write(rbes_pkg::CFG_IXZ, xz);
    reg_write(rbes_pkg::CFG_IYZ, yz);
  endtask

  task automatic send_tick(logic [15:0] dt, logic [31:0] fx, logic [31:0] fy,
                           logic [31:0] fz, logic [31:0] tx, logic [31:0] ty,
                           logic [31:0] tz);
    if ((sent < 500 || sent > 900) && $urandom_range(0, 99) < 14) begin
      in_valid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    step_time = dt; force_x = fx; force_y = fy; force_z = fz;
    torque_x = tx; torque_y = ty; torque_z = tz;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [15:0] dt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: dt = 16'($urandom);
        1: dt = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        default: dt = 16'($urandom_range(0, 4096));
      endcase
      send_tick(dt, pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q());
    end
    in_valid = 0;
  endtask

  // receiver: random stalls, one long hold-off, one stretch with no stalls
  initial begin
    int n;
    n = 0;
    forever begin
      @(negedge clk);
      n++;
      if (n >= 40000 && n < 42000) out_stall = 1;
      else if (n >= 60000 && n < 90000) out_stall = 0;
      else out_stall = ($urandom_range(0, 99) < 14);
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);
    // directed: zero step, max step, field extremes
    send_tick(16'h0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_tick(16'h1000, 32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0, 32'h0000_8000, 32'h0);
    send_tick(16'h0100, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
    send_tick(16'hffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_tick(16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_tick(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_tick(16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_tick(16'h0001, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
              32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
    in_valid = 0;
    // zero inverse mass, large skewed inertia
    load_body(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000);
    reg_write(3'd7, 32'hdead_beef);
    send_tick(16'h8000, 32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000,
              32'h0000_1000, 32'hffff_f000, 32'h0);
    send_tick(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_tick(16'hffff, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    in_valid = 0;
    // max inverse mass
    load_body(32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0, 32'h0, 32'h0);
    send_tick(16'hffff, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
    send_tick(16'h0010, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    in_valid = 0;
    random_ticks(400);
    load_body(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0001_0000,
              32'h0000_1000, 32'hffff_f000, 32'h0000_0800);
    random_ticks(600);
    load_body({1'b0, 31'($urandom)}, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
    random_ticks(500);
    load_body($urandom_range(1, 1 << 20), pick_q(), pick_q(), pick_q(),
              pick_q(), pick_q(), pick_q());
    random_ticks(500);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
